@@ rtl/core/lfu_pkg.sv @@
package lfu_pkg;

  // Register byte addresses on the configuration port.
  localparam int unsigned ADDR_CAPACITY = 0;
  localparam int unsigned PADDR_BITS    = 3;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // latch the item, clear the scan results, rewind the index
    logic issue;     // read the entry at the index and step the index
    logic sweep;     // data read now is rewritten instead of scanned
    logic decide;    // latch the update plan and the result, rewind the index
    logic load_out;  // move the result into the output register
  } lfu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic idx_last;
    logic need_sweep;
    logic out_free;
  } lfu_status_t;

endpackage

@@ rtl/core/lfu_ctrl.sv @@
module lfu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lfu_pkg::lfu_status_t st,
  output lfu_pkg::lfu_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_SCAN      = 7'b0000010,
    S_SCAN_END  = 7'b0000100,
    S_DECIDE    = 7'b0001000,
    S_SWEEP     = 7'b0010000,
    S_SWEEP_END = 7'b0100000,
    S_RESULT    = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        if (st.idx_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = st.need_sweep ? S_SWEEP : S_RESULT;
      end
      S_SWEEP: begin
        cmd.issue = 1'b1;
        cmd.sweep = 1'b1;
        if (st.idx_last) begin
          state_next = S_SWEEP_END;
        end
      end
      S_SWEEP_END: begin
        cmd.sweep = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/lfu_dp.sv @@
module lfu_dp #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lfu_pkg::lfu_cmd_t    cmd,
  output lfu_pkg::lfu_status_t st,
  input  logic                 operation,
  input  logic signed [31:0]   key,
  input  logic signed [31:0]   value,
  input  logic [4:0]           capacity,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 hit,
  output logic signed [31:0]   read_value,
  output logic                 evicted
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned AW = IW;
  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (FW > 5) ? FW : 5;
  localparam int unsigned EW = 64 + COUNT_BITS + AW;

  // Entry record: key, value, use count, age rank (0 is most recent).
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rdata;
  logic [CAPACITY-1:0] vbits;

  logic          op_q;
  logic [31:0]   key_q, val_q;
  logic [IW-1:0] idx, pend_idx;
  logic          pend, pend_sweep;

  // Scan results.
  logic [FW-1:0] fill;
  logic          found_f, free_f;
  logic [IW-1:0] found_idx, free_idx, vic_idx;
  logic [31:0]   found_val;
  logic [AW-1:0] found_age, vic_age;
  logic [COUNT_BITS-1:0] vic_cnt;

  // Update plan.
  logic          touch_q, ins_q, ev_q, res_hit_q;
  logic [IW-1:0] s_q;
  logic [AW-1:0] r_q;
  logic [31:0]   res_val_q;

  logic [31:0]           r_key, r_val;
  logic [COUNT_BITS-1:0] r_cnt;
  logic [AW-1:0]         r_age;
  logic                  r_v;

  assign r_key = rdata[EW-1 -: 32];
  assign r_val = rdata[EW-33 -: 32];
  assign r_cnt = rdata[AW +: COUNT_BITS];
  assign r_age = rdata[AW-1:0];
  assign r_v   = vbits[pend_idx];

  // Plan from the finished scan.
  logic [CW-1:0] cap_ext, cap_eff;
  logic          d_touch, d_ins, d_ev;
  logic [IW-1:0] d_s;
  logic [AW-1:0] d_r;
  logic [31:0]   d_val;

  always_comb begin
    cap_ext = CW'(capacity);
    cap_eff = (cap_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : cap_ext;
    d_touch = 1'b0;
    d_ins   = 1'b0;
    d_ev    = 1'b0;
    d_s     = found_idx;
    d_r     = found_age;
    d_val   = '0;
    if (op_q == lfu_pkg::OP_GET) begin
      d_val   = found_f ? found_val : '1;
      d_touch = found_f;
    end else if (cap_eff != '0) begin
      if (found_f) begin
        d_touch = 1'b1;
      end else begin
        d_ins = 1'b1;
        if (CW'(fill) >= cap_eff) begin
          d_ev = 1'b1;
          d_s  = vic_idx;
          d_r  = vic_age;
        end else begin
          d_s = free_idx;
        end
      end
    end
  end

  // Sweep write.
  logic          wr_en, at_s;
  logic [EW-1:0] wr_data;
  logic [COUNT_BITS-1:0] cnt_inc;

  always_comb begin
    at_s    = (pend_idx == s_q);
    cnt_inc = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
    wr_en   = pend && pend_sweep && (r_v || at_s);
    wr_data = rdata;
    if (touch_q) begin
      if (at_s) begin
        wr_data = {r_key, (op_q == lfu_pkg::OP_PUT) ? val_q : r_val, cnt_inc, AW'(0)};
      end else if (r_age < r_q) begin
        wr_data = {r_key, r_val, r_cnt, r_age + 1'b1};
      end
    end else begin
      if (at_s) begin
        wr_data = {key_q, val_q, COUNT_BITS'(1), AW'(0)};
      end else if (!(ev_q && r_age > r_q)) begin
        wr_data = {r_key, r_val, r_cnt, r_age + 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rdata <= mem[idx];
    end
    if (wr_en) begin
      mem[pend_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (pend && pend_sweep && ins_q && at_s) begin
      vbits[pend_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= cmd.issue;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx   <= idx;
    pend_sweep <= cmd.sweep;
    if (cmd.start || cmd.decide) begin
      idx <= '0;
    end else if (cmd.issue) begin
      idx <= idx + 1'b1;
    end
    if (cmd.start) begin
      op_q    <= operation;
      key_q   <= key;
      val_q   <= value;
      fill    <= '0;
      found_f <= 1'b0;
      free_f  <= 1'b0;
    end else if (pend && !pend_sweep) begin
      if (r_v) begin
        fill <= fill + 1'b1;
        if (r_key == key_q) begin
          found_f   <= 1'b1;
          found_idx <= pend_idx;
          found_val <= r_val;
          found_age <= r_age;
        end
        if (fill == '0 || r_cnt < vic_cnt || (r_cnt == vic_cnt && r_age > vic_age)) begin
          vic_idx <= pend_idx;
          vic_cnt <= r_cnt;
          vic_age <= r_age;
        end
      end else if (!free_f) begin
        free_f   <= 1'b1;
        free_idx <= pend_idx;
      end
    end
    if (cmd.decide) begin
      touch_q   <= d_touch;
      ins_q     <= d_ins;
      ev_q      <= d_ev;
      s_q       <= d_s;
      r_q       <= d_r;
      res_hit_q <= found_f;
      res_val_q <= d_val;
    end
    if (cmd.load_out) begin
      hit        <= res_hit_q;
      read_value <= res_val_q;
      evicted    <= ev_q;
    end
  end

  assign st.idx_last   = (idx == IW'(CAPACITY - 1));
  assign st.need_sweep = d_touch || d_ins;
  assign st.out_free   = !out_valid || out_ready;

endmodule

@@ rtl/core/lfu_cache_table.sv @@
// Channel   Handshake               Payload
// in        in_valid / in_ready     operation, key, value
// out       out_valid / out_ready   hit, read_value, evicted
// cfg       APB psel/penable        capacity at byte address 0
//
// A get miss, or a put while capacity is zero, makes one pass over the entry
// memory through its single read port to find the key, the fill, a free slot
// and the victim; any other item adds a second read-modify-write pass that
// updates age ranks, counts and the new entry. Reset clears the valid bits,
// the controller state, the read-pending flag and out_valid, and sets
// capacity to 16. A new item is taken while the last result still waits in
// the output register; a finished item holds until that register frees.
module lfu_cache_table #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           operation,
  input  logic signed [31:0]             key,
  input  logic signed [31:0]             value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic signed [31:0]             read_value,
  output logic                           evicted,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lfu_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [4:0] capacity;
  logic       cap_sel;

  lfu_pkg::lfu_cmd_t    cmd;
  lfu_pkg::lfu_status_t st;

  // The only register sits at the first word; other words read as zero.
  assign cap_sel = (paddr[lfu_pkg::PADDR_BITS-1:2] ==
                    1'(lfu_pkg::ADDR_CAPACITY >> 2));
  assign pready  = 1'b1;
  assign prdata  = cap_sel ? {27'd0, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= 5'd16;
    end else if (psel && penable && pwrite && cap_sel) begin
      capacity <= pwdata[4:0];
    end
  end

  lfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lfu_dp #(
    .CAPACITY   (CAPACITY),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .operation  (operation),
    .key        (key),
    .value      (value),
    .capacity   (capacity),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .read_value (read_value),
    .evicted    (evicted)
  );

endmodule
